@@ hdl/particle_euler_bounce_step_assert.svh @@
// Assertion macros for the particle Euler step block.
// Used by the top level; depends on nothing else.
`ifndef PARTICLE_EULER_BOUNCE_STEP_ASSERT_SVH
`define PARTICLE_EULER_BOUNCE_STEP_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PBS_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PBS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

@@ hdl/pbs_pkg.sv @@
// Shared types, register codes and Q8.16 arithmetic helpers for the particle step.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pbs_pkg;

  localparam int QW     = 24;
  localparam int DTW    = 16;
  localparam int FW     = 17;
  localparam int PW     = 48;
  localparam int FRAC   = 16;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef logic signed [QW-1:0] q_t;
  typedef logic signed [QW:0]   nq_t;
  typedef logic [DTW-1:0]       dt_t;
  typedef logic [FW-1:0]        fac_t;
  typedef logic signed [PW-1:0] wide_t;

  localparam wide_t QMAX = 48'sd8388607;
  localparam wide_t QMIN = -48'sd8388608;
  localparam wide_t HALF = 48'sd32768;

  typedef struct packed {
    q_t [2:0] pos;
    q_t [2:0] vel;
  } particle_t;

  typedef struct packed {
    dt_t  time_step;
    q_t   gravity_accel;
    fac_t drag_factor;
    fac_t bounce_factor;
    q_t   lower_bound;
    q_t   upper_bound;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_TIME_STEP = 3'd0,
    REG_GRAVITY   = 3'd1,
    REG_DRAG      = 3'd2,
    REG_BOUNCE    = 3'd3,
    REG_LOWER     = 3'd4,
    REG_UPPER     = 3'd5
  } reg_idx_t;

  localparam dt_t  RST_TIME_STEP = dt_t'(1092);
  localparam q_t   RST_GRAVITY   = q_t'(-98304);
  localparam fac_t RST_DRAG      = fac_t'(65470);
  localparam fac_t RST_BOUNCE    = fac_t'(39322);
  localparam q_t   RST_LOWER     = q_t'(-64225);
  localparam q_t   RST_UPPER     = q_t'(64225);

  function automatic q_t sat_q(input wide_t v);
    q_t r;
    if (v > QMAX) begin
      r = QMAX[QW-1:0];
    end else if (v < QMIN) begin
      r = QMIN[QW-1:0];
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

  // Round half toward plus infinity, then drop the fraction with flooring.
  function automatic q_t round_q(input wide_t prod);
    wide_t t;
    t = (prod + HALF) >>> FRAC;
    return sat_q(t);
  endfunction

  function automatic q_t mul_dt(input q_t a, input dt_t b);
    logic signed [QW+DTW:0] p;
    p = a * $signed({1'b0, b});
    return round_q(wide_t'(p));
  endfunction

  function automatic q_t mul_fac(input q_t a, input fac_t b);
    logic signed [QW+FW:0] p;
    p = a * $signed({1'b0, b});
    return round_q(wide_t'(p));
  endfunction

  function automatic q_t mul_neg(input nq_t a, input fac_t b);
    logic signed [QW+FW+1:0] p;
    p = a * $signed({1'b0, b});
    return round_q(wide_t'(p));
  endfunction

  function automatic q_t add_q(input q_t a, input q_t b);
    return sat_q(wide_t'(a) + wide_t'(b));
  endfunction

  function automatic q_t mirror_q(input q_t w, input q_t p);
    return sat_q(wide_t'(w) + wide_t'(w) - wide_t'(p));
  endfunction

  function automatic logic wall_hit(input q_t p, input q_t w, input logic upper);
    return upper ? (p > w) : (p < w);
  endfunction

endpackage

@@ hdl/pbs_cfg.sv @@
// APB register file holding the step, gravity, drag, bounce and wall settings.
// Depends on pbs_pkg.
`timescale 1ns / 1ps

module pbs_cfg import pbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr;
  reg_idx_t idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_step     <= RST_TIME_STEP;
      cfg.gravity_accel <= RST_GRAVITY;
      cfg.drag_factor   <= RST_DRAG;
      cfg.bounce_factor <= RST_BOUNCE;
      cfg.lower_bound   <= RST_LOWER;
      cfg.upper_bound   <= RST_UPPER;
    end else if (wr) begin
      unique case (idx)
        REG_TIME_STEP: cfg.time_step     <= pwdata[DTW-1:0];
        REG_GRAVITY:   cfg.gravity_accel <= pwdata[QW-1:0];
        REG_DRAG:      cfg.drag_factor   <= pwdata[FW-1:0];
        REG_BOUNCE:    cfg.bounce_factor <= pwdata[FW-1:0];
        REG_LOWER:     cfg.lower_bound   <= pwdata[QW-1:0];
        REG_UPPER:     cfg.upper_bound   <= pwdata[QW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TIME_STEP: prdata = DATA_W'(cfg.time_step);
      REG_GRAVITY:   prdata = DATA_W'(unsigned'(cfg.gravity_accel));
      REG_DRAG:      prdata = DATA_W'(cfg.drag_factor);
      REG_BOUNCE:    prdata = DATA_W'(cfg.bounce_factor);
      REG_LOWER:     prdata = DATA_W'(unsigned'(cfg.lower_bound));
      REG_UPPER:     prdata = DATA_W'(unsigned'(cfg.upper_bound));
      default:       prdata = '0;
    endcase
  end

endmodule

@@ hdl/pbs_vel.sv @@
// Velocity update: gravity product, gravity add on y, then drag on all axes.
// Three register stages with their own valid bits; depends on pbs_pkg.
`timescale 1ns / 1ps

module pbs_vel import pbs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  particle_t in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output particle_t out_data
);

  logic [2:0] vld;
  logic [2:0] adv;
  particle_t  s0, s1;
  q_t         gdt;

  assign adv[2]    = !vld[2] || !out_stall;
  assign adv[1]    = !vld[1] || adv[2];
  assign adv[0]    = !vld[0] || adv[1];
  assign in_stall  = !adv[0];
  assign out_valid = vld[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
    end
  end

  // Stage one forms the gravity increment for y.
  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      s0  <= in_data;
      gdt <= mul_dt(cfg.gravity_accel, cfg.time_step);
    end
  end

  // Stage two adds it to the y velocity.
  always_ff @(posedge clk) begin
    if (adv[1] && vld[0]) begin
      s1.pos    <= s0.pos;
      s1.vel[0] <= s0.vel[0];
      s1.vel[1] <= add_q(s0.vel[1], gdt);
      s1.vel[2] <= s0.vel[2];
    end
  end

  // Stage three applies drag to every axis.
  always_ff @(posedge clk) begin
    if (adv[2] && vld[1]) begin
      out_data.pos <= s1.pos;
      for (int i = 0; i < 3; i++) begin
        out_data.vel[i] <= mul_fac(s1.vel[i], cfg.drag_factor);
      end
    end
  end

endmodule

@@ hdl/pbs_pos.sv @@
// Position update: velocity times step, then saturating add to the position.
// Two register stages with their own valid bits; depends on pbs_pkg.
`timescale 1ns / 1ps

module pbs_pos import pbs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  particle_t in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output particle_t out_data
);

  logic [1:0] vld;
  logic [1:0] adv;
  particle_t  s0;
  q_t [2:0]   dpos;

  assign adv[1]    = !vld[1] || !out_stall;
  assign adv[0]    = !vld[0] || adv[1];
  assign in_stall  = !adv[0];
  assign out_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      s0 <= in_data;
      for (int i = 0; i < 3; i++) begin
        dpos[i] <= mul_dt(in_data.vel[i], cfg.time_step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1] && vld[0]) begin
      out_data.vel <= s0.vel;
      for (int i = 0; i < 3; i++) begin
        out_data.pos[i] <= add_q(s0.pos[i], dpos[i]);
      end
    end
  end

endmodule

@@ hdl/pbs_wall.sv @@
// One wall test on all three axes: compare and mirror, then scale the velocity.
// Two register stages with their own valid bits; depends on pbs_pkg.
`timescale 1ns / 1ps

module pbs_wall import pbs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_t        wall,
  input  logic      upper,
  input  fac_t      bounce,
  input  logic      in_valid,
  output logic      in_stall,
  input  particle_t in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output particle_t out_data
);

  logic [1:0] vld;
  logic [1:0] adv;
  particle_t  s0;
  logic [2:0] hit;
  nq_t        nvel [3];

  assign adv[1]    = !vld[1] || !out_stall;
  assign adv[0]    = !vld[0] || adv[1];
  assign in_stall  = !adv[0];
  assign out_valid = vld[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
    end
  end

  // The negated velocity is kept one bit wider so the most negative value
  // flips exactly before it is scaled.
  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      s0.vel <= in_data.vel;
      for (int i = 0; i < 3; i++) begin
        hit[i]  <= wall_hit(in_data.pos[i], wall, upper);
        nvel[i] <= -nq_t'(q_t'(in_data.vel[i]));
        s0.pos[i] <= wall_hit(in_data.pos[i], wall, upper) ?
                     mirror_q(wall, in_data.pos[i]) : in_data.pos[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1] && vld[0]) begin
      out_data.pos <= s0.pos;
      for (int i = 0; i < 3; i++) begin
        out_data.vel[i] <= hit[i] ? mul_neg(nvel[i], bounce) : s0.vel[i];
      end
    end
  end

endmodule

@@ hdl/particle_euler_bounce_step.sv @@
// Top level of the particle Euler step with wall bounce.
// Depends on pbs_pkg, pbs_cfg, pbs_vel, pbs_pos, pbs_wall and the assertion header.
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     in_valid / in_stall   in_pos_x..z, in_vel_x..z
// output    out_valid / out_stall out_pos_x..z, out_vel_x..z
// config    APB psel / penable    paddr, pwdata, prdata, pready
//
// One particle transfer is accepted per cycle while the input is not stalled; each result
// passes through the nine register stages of the pipeline after its input transfer.
// Reset is synchronous: all valid bits clear and the registers take their defaults.
// Each stage holds its item while the next one is full, so a stalled output
// fills the bubbles first and only then stalls the input; nothing is dropped.

`include "particle_euler_bounce_step_assert.svh"

module particle_euler_bounce_step import pbs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  q_t                in_pos_x,
  input  q_t                in_pos_y,
  input  q_t                in_pos_z,
  input  q_t                in_vel_x,
  input  q_t                in_vel_y,
  input  q_t                in_vel_z,
  output logic              out_valid,
  input  logic              out_stall,
  output q_t                out_pos_x,
  output q_t                out_pos_y,
  output q_t                out_pos_z,
  output q_t                out_vel_x,
  output q_t                out_vel_y,
  output q_t                out_vel_z
);

  cfg_t      cfg;
  particle_t p_in, p_vel, p_pos, p_low, p_out;
  logic      vel_valid, vel_stall;
  logic      pos_valid, pos_stall;
  logic      low_valid, low_stall;

  // Register file. Writes must come only while the pipeline is empty, as the
  // stages read the settings directly; the block itself does not enforce this.
  pbs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign p_in.pos[0] = in_pos_x;
  assign p_in.pos[1] = in_pos_y;
  assign p_in.pos[2] = in_pos_z;
  assign p_in.vel[0] = in_vel_x;
  assign p_in.vel[1] = in_vel_y;
  assign p_in.vel[2] = in_vel_z;

  // Stages one to three: gravity on y, then drag on all axes.
  pbs_vel u_vel (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (p_in),
    .out_valid (vel_valid),
    .out_stall (vel_stall),
    .out_data  (p_vel)
  );

  // Stages four and five: move each position by velocity times step.
  pbs_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (vel_valid),
    .in_stall  (vel_stall),
    .in_data   (p_vel),
    .out_valid (pos_valid),
    .out_stall (pos_stall),
    .out_data  (p_pos)
  );

  // Stages six and seven: lower wall test.
  pbs_wall u_wall_low (
    .clk       (clk),
    .rst       (rst),
    .wall      (cfg.lower_bound),
    .upper     (1'b0),
    .bounce    (cfg.bounce_factor),
    .in_valid  (pos_valid),
    .in_stall  (pos_stall),
    .in_data   (p_pos),
    .out_valid (low_valid),
    .out_stall (low_stall),
    .out_data  (p_low)
  );

  // Stages eight and nine: upper wall test on what the lower test left.
  pbs_wall u_wall_high (
    .clk       (clk),
    .rst       (rst),
    .wall      (cfg.upper_bound),
    .upper     (1'b1),
    .bounce    (cfg.bounce_factor),
    .in_valid  (low_valid),
    .in_stall  (low_stall),
    .in_data   (p_low),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (p_out)
  );

  assign out_pos_x = p_out.pos[0];
  assign out_pos_y = p_out.pos[1];
  assign out_pos_z = p_out.pos[2];
  assign out_vel_x = p_out.vel[0];
  assign out_vel_y = p_out.vel[1];
  assign out_vel_z = p_out.vel[2];

  // The input can only be held off once every stage is full and the output waits.
  `PBS_ASSERT(a_stall_full, clk, rst, in_stall |-> (out_valid && out_stall), "input stalled with room in the pipeline")
  // No result is offered right after reset.
  `PBS_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid, "result offered right after reset")
  // A write to the lower wall lands in the register.
  `PBS_ASSERT(a_cfg_lower, clk, rst, (!rst && psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_LOWER) |=> (cfg.lower_bound == $past(pwdata[QW-1:0])), "lower wall write lost")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for particle_euler_bounce_step: random and directed particles,
// an in-bench Q8.16 Euler step predictor, APB register setup and random flow control.
// Depends on pbs_pkg and the particle_euler_bounce_step RTL.
`timescale 1ns / 1ps

module testbench import pbs_pkg::*;;

  // Extremes of the signed Q8.16 range used by every field.
  localparam longint Q_HI = 8388607;
  localparam longint Q_LO = -8388608;

  // Register slots past the end of the map; writes to them must change nothing.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  // One particle as it crosses either channel. Index 0, 1, 2 is x, y, z.
  typedef struct {
    q_t pos[3];
    q_t vel[3];
  } particle_state_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  q_t                in_pos_x = '0;
  q_t                in_pos_y = '0;
  q_t                in_pos_z = '0;
  q_t                in_vel_x = '0;
  q_t                in_vel_y = '0;
  q_t                in_vel_z = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  q_t                out_pos_x;
  q_t                out_pos_y;
  q_t                out_pos_z;
  q_t                out_vel_x;
  q_t                out_vel_y;
  q_t                out_vel_z;

  particle_euler_bounce_step dut (.*);

  // The predictor's own copy of the six registers, loaded with the reset values.
  dt_t  step_dt  = RST_TIME_STEP;
  q_t   grav     = RST_GRAVITY;
  fac_t drag_f   = RST_DRAG;
  fac_t bounce_f = RST_BOUNCE;
  q_t   wall_lo  = RST_LOWER;
  q_t   wall_hi  = RST_UPPER;

  particle_state_t pending_particles[$];   // waiting for the driver
  particle_state_t expected_particles[$];  // predicted, waiting for the output side
  int  particles_queued = 0;
  int  particles_accepted = 0;
  int  mismatch_count = 0;
  bit  in_taken = 1'b0;  // the item on the input port was transferred at the last edge
  int  in_gap = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;      // when set, neither side inserts idle cycles
  string axis_tag[3] = '{"x", "y", "z"};

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: one explicit Euler step with wall reflection, in exact integer
  // arithmetic wide enough that nothing overflows before saturation.
  // ---------------------------------------------------------------------------

  function automatic longint clamp_q(input longint v);
    if (v > Q_HI) begin
      return Q_HI;
    end
    if (v < Q_LO) begin
      return Q_LO;
    end
    return v;
  endfunction

  // Product with an unsigned Q1.16 factor, rounded half up. The arithmetic
  // shift floors, which matches rounding toward plus infinity after adding half.
  function automatic longint scale_q16(input longint a, input longint f);
    longint prod;
    prod = a * f + 32768;
    return clamp_q(prod >>> 16);
  endfunction

  function automatic particle_state_t euler_bounce_step(input particle_state_t cur);
    longint pos[3];
    longint vel[3];
    longint dt;
    longint lo;
    longint hi;
    particle_state_t nxt;
    dt = longint'(step_dt);
    lo = longint'(wall_lo);
    hi = longint'(wall_hi);
    for (int i = 0; i < 3; i++) begin
      pos[i] = longint'(cur.pos[i]);
      vel[i] = longint'(cur.vel[i]);
    end
    // Gravity acts on y only, before drag.
    vel[1] = clamp_q(vel[1] + scale_q16(longint'(grav), dt));
    for (int i = 0; i < 3; i++) begin
      vel[i] = scale_q16(vel[i], longint'(drag_f));
      pos[i] = clamp_q(pos[i] + scale_q16(vel[i], dt));
      // The lower wall is tested first; the upper test sees what it left.
      // Negation is exact, so the most negative velocity becomes +2^23.
      if (pos[i] < lo) begin
        pos[i] = clamp_q(2 * lo - pos[i]);
        vel[i] = scale_q16(-vel[i], longint'(bounce_f));
      end
      if (pos[i] > hi) begin
        pos[i] = clamp_q(2 * hi - pos[i]);
        vel[i] = scale_q16(-vel[i], longint'(bounce_f));
      end
      nxt.pos[i] = q_t'(pos[i]);
      nxt.vel[i] = q_t'(vel[i]);
    end
    return nxt;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic particle_state_t make_particle(input longint px, input longint py,
                                                    input longint pz, input longint vx,
                                                    input longint vy, input longint vz);
    particle_state_t p;
    p.pos[0] = q_t'(px);
    p.pos[1] = q_t'(py);
    p.pos[2] = q_t'(pz);
    p.vel[0] = q_t'(vx);
    p.vel[1] = q_t'(vy);
    p.vel[2] = q_t'(vz);
    return p;
  endfunction

  // Signed value with magnitude below 2^bits.
  function automatic longint rand_mag(input int bits);
    longint m;
    m = longint'($urandom_range(0, (1 << bits) - 1));
    return ($urandom_range(0, 1) != 0) ? -m : m;
  endfunction

  // Any bit pattern at all, so every input bit sees both values.
  function automatic particle_state_t noise_particle();
    particle_state_t p;
    for (int i = 0; i < 3; i++) begin
      p.pos[i] = q_t'($urandom);
      p.vel[i] = q_t'($urandom);
    end
    return p;
  endfunction

  // Positions clustered around the walls and the middle between them, with
  // velocities of widely varying size, so that reflections happen often.
  function automatic particle_state_t wall_particle();
    particle_state_t p;
    longint anchor;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 2))
        0: anchor = longint'(wall_lo);
        1: anchor = longint'(wall_hi);
        default: anchor = (longint'(wall_lo) + longint'(wall_hi)) / 2;
      endcase
      p.pos[i] = q_t'(clamp_q(anchor + rand_mag($urandom_range(2, 18))));
      p.vel[i] = q_t'(rand_mag($urandom_range(4, 23)));
    end
    return p;
  endfunction

  task automatic queue_particle(input particle_state_t p);
    pending_particles.push_back(p);
    particles_queued++;
  endtask

  task automatic queue_random(input int count);
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_particle(noise_particle());
      end else begin
        queue_particle(wall_particle());
      end
    end
  endtask

  // APB write: setup cycle, then access cycle until pready. When scramble is
  // set, the bits above the register's width carry random junk.
  task automatic write_reg(input logic [2:0] idx, input longint value, input bit scramble);
    logic [31:0] keep;
    logic [31:0] word;
    case (idx) inside
      REG_TIME_STEP: keep = 32'h0000_ffff;
      REG_DRAG, REG_BOUNCE: keep = 32'h0001_ffff;
      default: keep = 32'h00ff_ffff;
    endcase
    word = 32'(value);
    if (scramble) begin
      word = ($urandom & ~keep) | (word & keep);
    end
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    // The register takes the word at this edge; the predictor follows.
    case (idx)
      REG_TIME_STEP: step_dt = word[15:0];
      REG_GRAVITY:   grav = q_t'(word[23:0]);
      REG_DRAG:      drag_f = word[16:0];
      REG_BOUNCE:    bounce_f = word[16:0];
      REG_LOWER:     wall_lo = q_t'(word[23:0]);
      REG_UPPER:     wall_hi = q_t'(word[23:0]);
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_config();
    longint lo_w;
    longint hi_w;
    write_reg(REG_TIME_STEP, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 4096), 1'b1);
    write_reg(REG_GRAVITY, rand_mag($urandom_range(8, 23)), 1'b1);
    write_reg(REG_DRAG, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                    : $urandom_range(60000, 65536), 1'b1);
    write_reg(REG_BOUNCE, $urandom_range(0, 131071), 1'b1);
    lo_w = rand_mag(22);
    // Mostly an ordered pair of walls; now and then the walls may cross.
    if ($urandom_range(0, 4) == 0) begin
      hi_w = rand_mag(22);
    end else begin
      hi_w = clamp_q(lo_w + longint'($urandom_range(0, 1 << 23)));
    end
    write_reg(REG_LOWER, lo_w, 1'b1);
    write_reg(REG_UPPER, hi_w, 1'b1);
  endtask

  // Wait until every queued particle has been transferred in and every
  // prediction has been matched, then let the pipeline settle.
  task automatic wait_idle();
    while (!(particles_accepted == particles_queued && expected_particles.size() == 0)) begin
      @(negedge clk);
    end
    repeat (12) @(negedge clk);
  endtask

  task automatic check_field(input string name, input q_t want, input q_t got);
    if (got !== want) begin
      $display("%0t: out_%s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver. A new particle goes out only once the previous one has been
  // transferred, so a stalled payload never changes. Idle bursts are decided
  // without looking at in_stall.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : feed_particles
    particle_state_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap != 0) begin
        in_gap = in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_particles.size() != 0) begin
        item = pending_particles.pop_front();
        in_pos_x <= item.pos[0];
        in_pos_y <= item.pos[1];
        in_pos_z <= item.pos[2];
        in_vel_x <= item.vel[0];
        in_vel_y <= item.vel[1];
        in_vel_z <= item.vel[2];
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure in bursts that start at random.
  always @(negedge clk) begin : throttle_results
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each rising edge an input transfer is turned into a prediction,
  // and an output transfer is compared with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_transfers
    particle_state_t taken;
    particle_state_t seen;
    particle_state_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        taken.pos[0] = in_pos_x;
        taken.pos[1] = in_pos_y;
        taken.pos[2] = in_pos_z;
        taken.vel[0] = in_vel_x;
        taken.vel[1] = in_vel_y;
        taken.vel[2] = in_vel_z;
        expected_particles.push_back(euler_bounce_step(taken));
        particles_accepted++;
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        seen.pos[0] = out_pos_x;
        seen.pos[1] = out_pos_y;
        seen.pos[2] = out_pos_z;
        seen.vel[0] = out_vel_x;
        seen.vel[1] = out_vel_y;
        seen.vel[2] = out_vel_z;
        if (expected_particles.size() == 0) begin
          $display("%0t: result transfer with nothing expected, expected none, got pos_x %0d",
                   $time, seen.pos[0]);
          mismatch_count++;
        end else begin
          want = expected_particles.pop_front();
          for (int i = 0; i < 3; i++) begin
            check_field({"pos_", axis_tag[i]}, want.pos[i], seen.pos[i]);
            check_field({"vel_", axis_tag[i]}, want.vel[i], seen.vel[i]);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence. Each phase programs the registers while the block is idle,
  // queues its particles, and waits for every result before moving on; that
  // wait also starves the pipeline completely between phases.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Reset register values: field extremes, particles sitting exactly on a
    // wall, one step past each wall, and particles flying into the walls.
    queue_particle(make_particle(0, 0, 0, 0, 0, 0));
    queue_particle(make_particle(Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI));
    queue_particle(make_particle(Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO));
    queue_particle(make_particle(-64225, -64225, -64225, 0, 0, 0));
    queue_particle(make_particle(64225, 64225, 64225, 0, 0, 0));
    queue_particle(make_particle(-64226, -64226, -64226, 0, 0, 0));
    queue_particle(make_particle(64226, 64226, 64226, 0, 0, 0));
    queue_particle(make_particle(-64000, -64000, -64000, -327680, -327680, -327680));
    queue_particle(make_particle(64000, 64000, 64000, 327680, 327680, 327680));
    queue_particle(make_particle(Q_HI, Q_LO, 0, Q_LO, Q_HI, 0));
    queue_random(250);
    wait_idle();

    // Longest step with unit drag and bounce and the floor at zero: a particle
    // at the floor with the most negative velocity hits the wall, and the
    // negated velocity no longer fits the range.
    write_reg(REG_TIME_STEP, 65535, 1'b0);
    write_reg(REG_GRAVITY, Q_HI, 1'b0);
    write_reg(REG_DRAG, 65536, 1'b0);
    write_reg(REG_BOUNCE, 65536, 1'b0);
    write_reg(REG_LOWER, 0, 1'b0);
    write_reg(REG_UPPER, Q_HI, 1'b0);
    queue_particle(make_particle(0, 0, 0, Q_LO, 0, Q_LO));
    queue_particle(make_particle(Q_LO, Q_HI, Q_LO, Q_HI, Q_LO, Q_HI));
    queue_random(100);
    wait_idle();

    // Drag and bounce factors near two: velocities grow and saturate.
    write_reg(REG_TIME_STEP, 4096, 1'b0);
    write_reg(REG_GRAVITY, -655360, 1'b0);
    write_reg(REG_DRAG, 131071, 1'b0);
    write_reg(REG_BOUNCE, 131071, 1'b0);
    write_reg(REG_LOWER, -262144, 1'b0);
    write_reg(REG_UPPER, 262144, 1'b0);
    queue_particle(make_particle(200000, -200000, 0, Q_HI, Q_LO, 3000000));
    queue_particle(make_particle(-250000, 250000, 260000, -Q_HI, 4000000, Q_HI));
    queue_random(100);
    wait_idle();

    // Crossed walls: a position between them trips both tests in turn.
    write_reg(REG_TIME_STEP, 1092, 1'b0);
    write_reg(REG_GRAVITY, -98304, 1'b0);
    write_reg(REG_DRAG, 65470, 1'b0);
    write_reg(REG_BOUNCE, 39322, 1'b0);
    write_reg(REG_LOWER, 65536, 1'b0);
    write_reg(REG_UPPER, -65536, 1'b0);
    queue_particle(make_particle(0, 0, 0, 0, 0, 0));
    queue_particle(make_particle(Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI));
    queue_particle(make_particle(Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO));
    queue_random(100);
    wait_idle();

    // Zero step, zero drag and bounce, walls at the range limits, and writes
    // to the unused register slots, which must leave everything unchanged.
    write_reg(REG_TIME_STEP, 0, 1'b0);
    write_reg(REG_GRAVITY, Q_LO, 1'b0);
    write_reg(REG_DRAG, 0, 1'b0);
    write_reg(REG_BOUNCE, 0, 1'b0);
    write_reg(REG_LOWER, Q_LO, 1'b0);
    write_reg(REG_UPPER, Q_HI, 1'b0);
    write_reg(REG_SPARE_A, 32'h0012_3456, 1'b0);
    write_reg(REG_SPARE_B, -1, 1'b0);
    queue_particle(make_particle(Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI));
    queue_particle(make_particle(Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO));
    queue_random(100);
    wait_idle();

    // Random settings; every third phase runs without idle cycles.
    for (int k = 0; k < 6; k++) begin
      calm = (k % 3 == 2);
      random_config();
      queue_random(120);
      wait_idle();
    end

    // Back to the reset values, full rate on both sides to the end.
    calm = 1'b1;
    write_reg(REG_TIME_STEP, RST_TIME_STEP, 1'b1);
    write_reg(REG_GRAVITY, RST_GRAVITY, 1'b1);
    write_reg(REG_DRAG, RST_DRAG, 1'b1);
    write_reg(REG_BOUNCE, RST_BOUNCE, 1'b1);
    write_reg(REG_LOWER, RST_LOWER, 1'b1);
    write_reg(REG_UPPER, RST_UPPER, 1'b1);
    queue_random(180);
    wait_idle();
    repeat (20) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hang: far longer than the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/pbs_pkg.sv
hdl/pbs_cfg.sv
hdl/pbs_vel.sv
hdl/pbs_pos.sv
hdl/pbs_wall.sv
hdl/particle_euler_bounce_step.sv
verif/testbench.sv
